@@ rtl/hbl_pkg.sv @@
`default_nettype none
package hbl_pkg;

   localparam int SLOTS = 8;
   localparam int SLOT_W = 3;
   localparam int NUM_BUCKETS = 1024;
   localparam int BUCKET_W = 10;
   localparam int KEY_W = 160;
   localparam int NB_W = 11;
   localparam int CS_W = 21;
   localparam int LOC_W = 33;
   localparam int CNT_W = 10;

   localparam logic [31:0] HASH_SEED = 32'd2;
   localparam logic [31:0] FP_BYTES = 32'd20;
   localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2 = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
   localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;
   localparam logic [NB_W-1:0] MAX_NB = NB_W'(NUM_BUCKETS);
   localparam logic [CS_W-1:0] MAX_CS = CS_W'(1048576);
   localparam logic [NB_W-1:0] RESET_NB = NB_W'(1024);
   localparam logic [CS_W-1:0] RESET_CS = CS_W'(4096);

   localparam logic REG_BUCKET_COUNT = 1'b0;
   localparam logic REG_CHUNK_SIZE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MIX1, ST_MIX2, ST_MIX3, ST_FIN1, ST_FIN2, ST_FIN3,
      ST_DIV, ST_READ, ST_DECIDE, ST_WRITE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_MIX1, OP_MIX2, OP_MIX3, OP_FIN1, OP_FIN2,
      OP_FIN3, OP_DIV, OP_READ, OP_DECIDE, OP_WRITE
   } op_type;

   typedef struct packed {
      op_type op;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   typedef struct packed {
      logic valid;
      logic [SLOT_W-1:0] rank;
      logic [KEY_W-1:0] key;
   } slot_type;

   typedef slot_type [SLOTS-1:0] row_type;

endpackage
`default_nettype wire

@@ rtl/hashed_bucket_lru_fingerprint_index_core.sv @@
// An accepted req word goes through hash mixing, finalization and the bit-serial,
// one-bit-per-cycle modulo, then read, update and write before rsp_tvalid.
// A new word is taken only after the last one is written back, as req_tready
// stays low until then; a result still held back by rsp_tready adds its wait.
// Reset is synchronous; afterwards a clearing pass zeroes every bucket row
// before req_tready rises. Configuration writes are taken at any time.
`default_nettype none
module hashed_bucket_lru_fingerprint_index_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // fp_word0[63:0], fp_word1[127:64], fp_word2[159:128]
   input  wire logic [159:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // bucket[9:0], slot[12:10], location[45:13], zero fill
   output logic [47:0] rsp_tdata,
   // hit[0], evicted[1]
   output logic [1:0] rsp_tuser,
   input  wire logic csr_we,
   input  wire logic csr_addr,
   input  wire logic [hbl_pkg::CS_W-1:0] csr_wdata
);
   import hbl_pkg::*;

   cmd_type cmd;
   status_type status;

   hbl_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   hbl_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_tdata(req_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );
endmodule
`default_nettype wire

@@ rtl/hbl_ctrl.sv @@
`default_nettype none
module hbl_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire hbl_pkg::status_type status,
   output hbl_pkg::cmd_type cmd
);
   import hbl_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
               cnt_in = '0;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MIX1;
               cnt_in = '0;
            end
         end
         ST_MIX1: state_in = ST_MIX2;
         ST_MIX2: state_in = ST_MIX3;
         ST_MIX3: begin
            if (cnt_ff == CNT_W'(4)) begin
               state_in = ST_FIN1;
               cnt_in = '0;
            end else begin
               state_in = ST_MIX1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN1: state_in = ST_FIN2;
         ST_FIN2: state_in = ST_FIN3;
         ST_FIN3: begin
            state_in = ST_DIV;
            cnt_in = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(31)) begin
               state_in = ST_READ;
               cnt_in = '0;
            end
         end
         ST_READ: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_WRITE;
         ST_WRITE: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.cnt = cnt_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_CLEAR: cmd.op = OP_CLEAR;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.op = req_tvalid ? OP_LOAD : OP_NONE;
         end
         ST_MIX1: cmd.op = OP_MIX1;
         ST_MIX2: cmd.op = OP_MIX2;
         ST_MIX3: cmd.op = OP_MIX3;
         ST_FIN1: cmd.op = OP_FIN1;
         ST_FIN2: cmd.op = OP_FIN2;
         ST_FIN3: cmd.op = OP_FIN3;
         ST_DIV: cmd.op = OP_DIV;
         ST_READ: cmd.op = OP_READ;
         ST_DECIDE: cmd.op = OP_DECIDE;
         ST_WRITE: cmd.op = status.rsp_busy ? OP_NONE : OP_WRITE;
         default: cmd.op = OP_NONE;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/hbl_datapath.sv @@
`default_nettype none
module hbl_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire hbl_pkg::cmd_type cmd,
   output hbl_pkg::status_type status,
   input  wire logic [159:0] req_tdata,
   input  wire logic csr_we,
   input  wire logic csr_addr,
   input  wire logic [hbl_pkg::CS_W-1:0] csr_wdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic [1:0] rsp_tuser
);
   import hbl_pkg::*;

   logic [KEY_W-1:0] fp_ff;
   logic [31:0] h_ff, h_in;
   logic [31:0] k_ff, k_in;
   logic [NB_W-1:0] rem_ff, rem_in;
   logic [BUCKET_W-1:0] bucket_ff;
   logic [NB_W-1:0] nb_reg_ff;
   logic [CS_W-1:0] cs_reg_ff;
   logic [NB_W-1:0] nb;
   logic [CS_W-1:0] cs;
   row_type mem [NUM_BUCKETS];
   row_type rd_ff;
   row_type row_in;
   row_type row_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic hit_ff, hit_in, evict_ff, evict_in;
   logic rsp_valid_ff;
   logic [BUCKET_W-1:0] rsp_bucket_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [LOC_W-1:0] rsp_loc_ff;
   logic rsp_hit_ff, rsp_evict_ff;
   logic [31:0] word;
   logic [31:0] t;
   logic [NB_W-1:0] r_sh;
   logic [33:0] loc_full;

   always_comb begin
      unique case (cmd.cnt[2:0])
         3'd0: word = fp_ff[31:0];
         3'd1: word = fp_ff[63:32];
         3'd2: word = fp_ff[95:64];
         3'd3: word = fp_ff[127:96];
         default: word = fp_ff[159:128];
      endcase
   end

   always_comb begin
      nb = nb_reg_ff;
      if (nb_reg_ff == '0) nb = NB_W'(1);
      else if (nb_reg_ff > MAX_NB) nb = MAX_NB;
      cs = cs_reg_ff;
      if (cs_reg_ff == '0) cs = CS_W'(1);
      else if (cs_reg_ff > MAX_CS) cs = MAX_CS;
   end

   // Hash unit: at most one multiply per step, then a bit-serial modulo.
   always_comb begin
      h_in = h_ff;
      k_in = k_ff;
      rem_in = rem_ff;
      t = '0;
      r_sh = {rem_ff[NB_W-2:0], h_ff[~cmd.cnt[4:0]]};
      unique case (cmd.op)
         OP_LOAD: h_in = HASH_SEED;
         OP_MIX1: k_in = word * MIX_C1;
         OP_MIX2: k_in = {k_ff[16:0], k_ff[31:17]} * MIX_C2;
         OP_MIX3: begin
            t = h_ff ^ k_ff;
            t = {t[18:0], t[31:19]};
            h_in = (t << 2) + t + MIX_ADD;
         end
         OP_FIN1: begin
            t = h_ff ^ FP_BYTES;
            t = t ^ (t >> 16);
            h_in = t * FMIX_C1;
         end
         OP_FIN2: begin
            t = h_ff ^ (h_ff >> 13);
            h_in = t * FMIX_C2;
         end
         OP_FIN3: begin
            h_in = h_ff ^ (h_ff >> 16);
            rem_in = '0;
         end
         OP_DIV: rem_in = (r_sh >= nb) ? r_sh - nb : r_sh;
         default: ;
      endcase
   end

   // Bucket update: find a hit, else the lowest free slot, else the least recent.
   always_comb begin
      logic found;
      logic free_found;
      logic [SLOT_W-1:0] best;
      logic [SLOT_W:0] r;
      found = 1'b0;
      free_found = 1'b0;
      best = '0;
      slot_in = '0;
      evict_in = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!found && rd_ff[i].valid && rd_ff[i].key == fp_ff) begin
            found = 1'b1;
            slot_in = SLOT_W'(i);
         end
      end
      if (!found) begin
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!rd_ff[i].valid) begin
               free_found = 1'b1;
               slot_in = SLOT_W'(i);
            end
         end
         if (!free_found) begin
            evict_in = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
               if (rd_ff[i].rank >= best) begin
                  best = rd_ff[i].rank;
                  slot_in = SLOT_W'(i);
               end
            end
         end
      end
      hit_in = found;
      r = free_found ? (SLOT_W+1)'(SLOTS) : {1'b0, rd_ff[slot_in].rank};
      row_in = rd_ff;
      for (int i = 0; i < SLOTS; i++) begin
         if (SLOT_W'(i) != slot_in && rd_ff[i].valid && {1'b0, rd_ff[i].rank} < r)
            row_in[i].rank = rd_ff[i].rank + 1'b1;
      end
      row_in[slot_in].rank = '0;
      row_in[slot_in].valid = 1'b1;
      row_in[slot_in].key = fp_ff;
   end

   assign loc_full = {bucket_ff, slot_ff} * cs;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLEAR) mem[cmd.cnt] <= '0;
      else if (cmd.op == OP_WRITE) mem[bucket_ff] <= row_ff;
      if (cmd.op == OP_READ) rd_ff <= mem[rem_ff[BUCKET_W-1:0]];
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      k_ff <= k_in;
      rem_ff <= rem_in;
      if (cmd.op == OP_LOAD) fp_ff <= req_tdata;
      if (cmd.op == OP_READ) bucket_ff <= rem_ff[BUCKET_W-1:0];
      if (cmd.op == OP_DECIDE) begin
         row_ff <= row_in;
         slot_ff <= slot_in;
         hit_ff <= hit_in;
         evict_ff <= evict_in;
      end
      if (cmd.op == OP_WRITE) begin
         rsp_bucket_ff <= bucket_ff;
         rsp_slot_ff <= slot_ff;
         rsp_loc_ff <= loc_full[LOC_W-1:0];
         rsp_hit_ff <= hit_ff;
         rsp_evict_ff <= evict_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_reg_ff <= RESET_NB;
         cs_reg_ff <= RESET_CS;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_addr == REG_BUCKET_COUNT) nb_reg_ff <= csr_wdata[NB_W-1:0];
         if (csr_we && csr_addr == REG_CHUNK_SIZE) cs_reg_ff <= csr_wdata;
         if (cmd.op == OP_WRITE) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_loc_ff, rsp_slot_ff, rsp_bucket_ff};
   assign rsp_tuser = {rsp_evict_ff, rsp_hit_ff};
endmodule
`default_nettype wire
